[rtl/hdmbc_pkg.sv]
// ----------------------------------------------------------------------------
// hdmbc_pkg
// Shared types and constants of the hashed direct-mapped block cache tag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hdmbc_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CS_W      = 11;
    localparam int WORD_W    = 32;

    localparam logic [WORD_W-1:0] HASH_MULT_RESET = 32'h9E37_79B1;

    // Remainder unit: bits of the product consumed per cycle
    localparam int DIV_BPS   = 4;
    localparam int DIV_STEPS = WORD_W / DIV_BPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    // Register word index (paddr[2])
    localparam logic REG_CACHE_SLOTS = 1'b0;
    localparam logic REG_HASH_MULT   = 1'b1;
    localparam int   PADDR_W         = 3;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_FILL_DONE = 3'd2,
        ST_FILL_FAIL = 3'd3,
        ST_NOT_BLOCK = 3'd4,
        ST_BYPASS    = 3'd5,
        ST_PROTO     = 3'd6
    } status_t;

    typedef struct packed {
        logic [CS_W-1:0]   cache_slots;
        logic [WORD_W-1:0] hash_multiplier;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] device;
        logic [WORD_W-1:0] block;
    } tag_entry_t;

    localparam int TAG_W = $bits(tag_entry_t);

endpackage

`default_nettype wire

[rtl/hdmbc_if.sv]
// ----------------------------------------------------------------------------
// hdmbc_in_if / hdmbc_out_if
// Valid/ready channels carrying requests into and results out of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdmbc_in_if
    import hdmbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [WORD_W-1:0] device_handle;
    logic [WORD_W-1:0] block_number;
    logic              is_block_device;
    logic              fill_ok;

    modport source (
        output valid, action, device_handle, block_number, is_block_device, fill_ok,
        input  ready
    );
    modport sink (
        input  valid, action, device_handle, block_number, is_block_device, fill_ok,
        output ready
    );
endinterface

interface hdmbc_out_if
    import hdmbc_pkg::*;
;
    logic              valid;
    logic              ready;
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] fetch_block;
    logic [WORD_W-1:0] hit_count;
    logic [WORD_W-1:0] miss_count;
    logic [WORD_W-1:0] read_count;

    modport source (
        output valid, status, slot_index, fetch_block, hit_count, miss_count, read_count,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, fetch_block, hit_count, miss_count, read_count,
        output ready
    );
endinterface

`default_nettype wire

[rtl/hdmbc_ram.sv]
// ----------------------------------------------------------------------------
// hdmbc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/hdmbc_cfg.sv]
// ----------------------------------------------------------------------------
// hdmbc_cfg
// APB register file: slot count and hash multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmbc_cfg
    import hdmbc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0]  pwdata,
    output logic      [WORD_W-1:0]  prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [CS_W-1:0]   slots_reg;
    logic [WORD_W-1:0] mult_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
            mult_reg  <= HASH_MULT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_CACHE_SLOTS: slots_reg <= pwdata[CS_W-1:0];
                REG_HASH_MULT:   mult_reg  <= pwdata;
                default:         slots_reg <= slots_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CACHE_SLOTS: prdata = WORD_W'(slots_reg);
            REG_HASH_MULT:   prdata = mult_reg;
            default:         prdata = '0;
        endcase
    end

    assign cfg.cache_slots     = slots_reg;
    assign cfg.hash_multiplier = mult_reg;

endmodule

`default_nettype wire

[rtl/hdmbc_hash.sv]
// ----------------------------------------------------------------------------
// hdmbc_hash
// Slot hash: registered 32-bit product, then remainder by the slot count,
// DIV_BPS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hdmbc_hash
    import hdmbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] key,
    input  wire logic [WORD_W-1:0] mult,
    input  wire logic [CS_W-1:0]   n,
    output logic                   done,
    output logic [SLOT_W-1:0]      slot
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [SLOT_W-1:0] rem_reg;
    logic [WORD_W-1:0] prod_lo;
    logic [SLOT_W-1:0] rem_next;
    logic [SLOT_W:0]   trial;

    assign prod_lo = key * mult;

    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BPS; i++)
        begin
            trial = {rem_next, prod_reg[WORD_W-1-i]};
            if (trial >= (SLOT_W+1)'(n))
            begin
                trial = trial - (SLOT_W+1)'(n);
            end
            rem_next = trial[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_lo;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_reg << DIV_BPS;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign slot = rem_reg;

endmodule

`default_nettype wire

[rtl/hashed_direct_mapped_block_cache_tags_unit.sv]
// ----------------------------------------------------------------------------
// hashed_direct_mapped_block_cache_tags_unit
// Tag controller for a direct-mapped block cache with a hashed slot index.
// ----------------------------------------------------------------------------
// One request is handled at a time. A lookup that reaches the tag store goes
// from transfer through decode and the start of the 32x32 multiply, the
// remainder by the slot count (4 bits per cycle), one tag RAM read and one
// compare, and then back to idle. Fills, rejects, bypasses and protocol errors
// are answered from the decode step. The result register frees the input side
// while a result waits. After reset a clearing pass writes every one of the
// 1024 tag entries invalid, one per cycle, and no request is accepted until it
// ends; register writes are taken throughout.
`default_nettype none

module hashed_direct_mapped_block_cache_tags_unit
    import hdmbc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0]  pwdata,
    output logic      [WORD_W-1:0]  prdata,
    output logic                    pready,
    hdmbc_in_if.sink                req,
    hdmbc_out_if.source             rsp
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_HASH  = 5'b01000,
        S_CMP   = 5'b10000
    } state_t;

    cfg_t              cfg;
    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;

    logic              act_reg;
    logic [WORD_W-1:0] dev_reg;
    logic [WORD_W-1:0] blk_reg;
    logic              isblk_reg;
    logic              ok_reg;

    logic              pending_reg, pending_next;
    logic [SLOT_W-1:0] pslot_reg, pslot_next;
    logic [WORD_W-1:0] pdev_reg, pdev_next;
    logic [WORD_W-1:0] pblk_reg, pblk_next;
    logic [WORD_W-1:0] hits_reg, hits_next;
    logic [WORD_W-1:0] misses_reg, misses_next;
    logic [WORD_W-1:0] reads_reg, reads_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [WORD_W-1:0] out_fetch_reg, out_fetch_next;
    logic [WORD_W-1:0] out_hits_reg;
    logic [WORD_W-1:0] out_misses_reg;
    logic [WORD_W-1:0] out_reads_reg;
    logic              emit;
    logic              out_free;

    logic [CS_W-1:0]   n_use;
    logic              hash_start;
    logic              hash_done;
    logic [SLOT_W-1:0] hash_slot;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    tag_entry_t        ram_wdata;
    logic              ram_re;
    logic [TAG_W-1:0]  ram_rdata;
    tag_entry_t        entry;
    logic              hit;
    logic              accept;

    hdmbc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign n_use = (cfg.cache_slots > CS_W'(MAX_SLOTS)) ? CS_W'(MAX_SLOTS) : cfg.cache_slots;

    hdmbc_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (dev_reg ^ blk_reg),
        .mult  (cfg.hash_multiplier),
        .n     (n_use),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    hdmbc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (MAX_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (hash_slot),
        .rdata (ram_rdata)
    );

    assign entry    = tag_entry_t'(ram_rdata);
    assign hit      = entry.valid && (entry.device == dev_reg) && (entry.block == blk_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign accept   = req.valid && req.ready;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        pending_next    = pending_reg;
        pslot_next      = pslot_reg;
        pdev_next       = pdev_reg;
        pblk_next       = pblk_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        reads_next      = reads_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_fetch_next  = out_fetch_reg;
        emit            = 1'b0;
        hash_start      = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = clr_idx_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SLOT_W'(MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (act_reg == ACT_FILL || pending_reg || !isblk_reg || n_use == '0)
                begin
                    if (out_free)
                    begin
                        emit          = 1'b1;
                        state_next    = S_IDLE;
                        out_slot_next = '0;
                        out_fetch_next = '0;
                        priority if (act_reg == ACT_FILL && pending_reg)
                        begin
                            pending_next   = 1'b0;
                            out_slot_next  = pslot_reg;
                            out_fetch_next = pblk_reg;
                            if (ok_reg)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = pslot_reg;
                                ram_wdata.valid = 1'b1;
                                ram_wdata.device = pdev_reg;
                                ram_wdata.block = pblk_reg;
                                misses_next     = misses_reg + 1'b1;
                                reads_next      = reads_reg + 1'b1;
                                out_status_next = ST_FILL_DONE;
                            end
                            else
                            begin
                                out_status_next = ST_FILL_FAIL;
                            end
                        end
                        else if (act_reg == ACT_FILL || pending_reg)
                        begin
                            out_status_next = ST_PROTO;
                        end
                        else if (!isblk_reg)
                        begin
                            out_status_next = ST_NOT_BLOCK;
                        end
                        else
                        begin
                            out_status_next = ST_BYPASS;
                            out_fetch_next  = blk_reg;
                        end
                    end
                end
                else
                begin
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    ram_re     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    state_next    = S_IDLE;
                    out_slot_next = hash_slot;
                    if (hit)
                    begin
                        hits_next       = hits_reg + 1'b1;
                        reads_next      = reads_reg + 1'b1;
                        out_status_next = ST_HIT;
                        out_fetch_next  = '0;
                    end
                    else
                    begin
                        pending_next    = 1'b1;
                        pslot_next      = hash_slot;
                        pdev_next       = dev_reg;
                        pblk_next       = blk_reg;
                        out_status_next = ST_MISS;
                        out_fetch_next  = blk_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            pending_reg   <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            reads_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            pending_reg   <= pending_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            reads_reg     <= reads_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= req.action;
            dev_reg   <= req.device_handle;
            blk_reg   <= req.block_number;
            isblk_reg <= req.is_block_device;
            ok_reg    <= req.fill_ok;
        end
        pslot_reg <= pslot_next;
        pdev_reg  <= pdev_next;
        pblk_reg  <= pblk_next;
        if (emit)
        begin
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_fetch_reg  <= out_fetch_next;
            out_hits_reg   <= hits_next;
            out_misses_reg <= misses_next;
            out_reads_reg  <= reads_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.fetch_block = out_fetch_reg;
    assign rsp.hit_count   = out_hits_reg;
    assign rsp.miss_count  = out_misses_reg;
    assign rsp.read_count  = out_reads_reg;

endmodule

`default_nettype wire
